// ----- hw/rtl/f8q_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled quantizer package
// Shared constants and helpers for the FP32 to FP8 quantizer.
// ----------------------------------------------------------------------------
package f8q_pkg;

    localparam logic [31:0] QNAN_DEFAULT  = 32'h7FC0_0000;
    localparam logic [31:0] E4M3_MAX_BITS = 32'h43E0_0000;
    localparam logic [31:0] E5M2_MAX_BITS = 32'h4760_0000;
    localparam logic [31:0] SCALE_RESET   = 32'h3F80_0000;

    localparam logic [1:0] ADDR_SCALE  = 2'd0;
    localparam logic [1:0] ADDR_FORMAT = 2'd1;

    typedef enum logic
    {
        FMT_E4M3 = 1'b0,
        FMT_E5M2 = 1'b1
    } fmt_t;

    // Leading zero count of a 23-bit subnormal mantissa field (nonzero input).
    function automatic logic [4:0] lzc23(input logic [22:0] m);
        logic [4:0] n;
        logic       found;
        n = 5'd23;
        found = 1'b0;
        for (int i = 22; i >= 0; i--)
        begin
            if (!found && m[i])
            begin
                n = 5'(22 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ----- hw/rtl/fp32_to_fp8_scaled_quantizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FP32 to FP8 scaled quantizer
// Multiplies each binary32 value by a configured inverse scale and emits an
// E4M3 or E5M2 byte.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream (s_axis_*) carries one binary32 value per request in
//   s_axis_tdata. The output stream (m_axis_*) carries one FP8 code per
//   request in the low byte of m_axis_tdata. Every input gives one output.
//   The APB port writes inverse_scale at address 0 and format_select at
//   address 4; write them only while the stream is idle.
//   Each request is registered at every stage on its way to m_axis_tvalid.
//   The pipeline takes one request per cycle unless a receiver stall reaches
//   the first stage; the 24x24 mantissa multiply in stage two and the
//   normalizing shift in stage three set the stage depth. When the receiver
//   stalls, stages behind a full stage hold, bubbles fill, and s_axis_tready
//   falls only where a bubble cannot absorb the request, so nothing is lost or repeated.
//   Reset empties the pipeline and restores inverse_scale to 1.0 and the
//   format to E4M3.
// ----------------------------------------------------------------------------
module fp32_to_fp8_scaled_quantizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value_bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] fp8_code
);
    import f8q_pkg::*;

    logic [31:0] scale_reg;
    fmt_t        fmt_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            fmt_reg   <= FMT_E4M3;
        end
        else if (psel && penable && pwrite)
        begin
            if ({1'b0, paddr[2]} == ADDR_SCALE)
                scale_reg <= pwdata;
            else if ({1'b0, paddr[2]} == ADDR_FORMAT)
                fmt_reg <= fmt_t'(pwdata[0]);
        end
    end

    always_comb
    begin
        prdata = '0;
        if ({1'b0, paddr[2]} == ADDR_SCALE)
            prdata = scale_reg;
        else if ({1'b0, paddr[2]} == ADDR_FORMAT)
            prdata = {31'd0, fmt_reg};
    end

    // Pipeline valid bits; stage k advances when the stage after it frees up.
    logic [4:0] vld_reg;
    logic [4:0] adv;

    assign adv[4] = !vld_reg[4] || m_axis_tready;
    assign adv[3] = !vld_reg[3] || adv[4];
    assign adv[2] = !vld_reg[2] || adv[3];
    assign adv[1] = !vld_reg[1] || adv[2];
    assign adv[0] = !vld_reg[0] || adv[1];
    assign s_axis_tready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0]) vld_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < 5; k++)
                if (adv[k]) vld_reg[k] <= vld_reg[k-1];
        end
    end

    // ---------------- Stage 1: classify and unpack operands ----------------
    logic [31:0] a_in;
    logic [30:0] aa, ab;
    logic        sp_next;
    logic [31:0] spv_next;
    logic [4:0]  lza, lzb;

    assign a_in = s_axis_tdata;
    assign aa = a_in[30:0];
    assign ab = scale_reg[30:0];
    assign lza = lzc23(aa[22:0]);
    assign lzb = lzc23(ab[22:0]);

    always_comb
    begin
        sp_next  = 1'b1;
        spv_next = '0;
        if (aa > 31'h7F80_0000)
            spv_next = a_in | 32'h0040_0000;
        else if (ab > 31'h7F80_0000)
            spv_next = scale_reg | 32'h0040_0000;
        else if ((aa == 31'h7F80_0000 && ab == 31'd0) ||
                 (ab == 31'h7F80_0000 && aa == 31'd0))
            spv_next = QNAN_DEFAULT;
        else if (aa == 31'h7F80_0000 || ab == 31'h7F80_0000)
            spv_next = {a_in[31] ^ scale_reg[31], 31'h7F80_0000};
        else if (aa == 31'd0 || ab == 31'd0)
            spv_next = {a_in[31] ^ scale_reg[31], 31'd0};
        else
            sp_next = 1'b0;
    end

    logic        s1_sp_reg, s1_sign_reg;
    logic [31:0] s1_spv_reg;
    logic [9:0]  s1_e_reg;          // signed ea + eb - 127
    logic [23:0] s1_ma_reg, s1_mb_reg;
    fmt_t        s1_fmt_reg;

    logic signed [9:0] ea_s, eb_s;
    logic [23:0] ma_n, mb_n;

    always_comb
    begin
        if (aa[30:23] != 8'd0)
        begin
            ea_s = 10'(aa[30:23]);
            ma_n = {1'b1, aa[22:0]};
        end
        else
        begin
            ea_s = 10'sd1 - 10'(lza) - 10'sd1;
            ma_n = {aa[22:0], 1'b0} << lza;
        end
        if (ab[30:23] != 8'd0)
        begin
            eb_s = 10'(ab[30:23]);
            mb_n = {1'b1, ab[22:0]};
        end
        else
        begin
            eb_s = 10'sd1 - 10'(lzb) - 10'sd1;
            mb_n = {ab[22:0], 1'b0} << lzb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_sp_reg   <= sp_next;
            s1_spv_reg  <= spv_next;
            s1_sign_reg <= a_in[31] ^ scale_reg[31];
            s1_e_reg    <= ea_s + eb_s - 10'sd127;
            s1_ma_reg   <= ma_n;
            s1_mb_reg   <= mb_n;
            s1_fmt_reg  <= fmt_reg;
        end
    end

    // ---------------- Stage 2: mantissa product ----------------
    logic        s2_sp_reg, s2_sign_reg;
    logic [31:0] s2_spv_reg;
    logic [9:0]  s2_e_reg;
    logic [47:0] s2_p_reg;
    fmt_t        s2_fmt_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_sp_reg   <= s1_sp_reg;
            s2_spv_reg  <= s1_spv_reg;
            s2_sign_reg <= s1_sign_reg;
            s2_e_reg    <= s1_e_reg;
            s2_p_reg    <= s1_ma_reg * s1_mb_reg;
            s2_fmt_reg  <= s1_fmt_reg;
        end
    end

    // ---------------- Stage 3: normalize and round the product ----------------
    logic signed [9:0] e2;
    logic [47:0] pn;
    logic [6:0]  sh;
    logic [48:0] ext;
    logic [24:0] keep;
    logic        rnd, sticky;
    logic [31:0] prod;
    logic signed [10:0] ef;

    always_comb
    begin
        if (s2_p_reg[47])
        begin
            e2 = $signed(s2_e_reg) + 10'sd1;
            pn = s2_p_reg;
        end
        else
        begin
            e2 = $signed(s2_e_reg);
            pn = {s2_p_reg[46:0], 1'b0};
        end
        if (e2 >= 10'sd1)
            sh = 7'd24;
        else if (e2 > -10'sd40)
            sh = 7'(10'sd25 - e2);
        else
            sh = 7'd64;
        ext = '0;
        if (sh >= 7'd64)
        begin
            keep = '0;
            rnd = 1'b0;
        end
        else
        begin
            ext = {pn, 1'b0} >> sh;
            keep = ext[25:1];
            rnd = ext[0];
        end
        sticky = (sh >= 7'd64) ? 1'b1
               : ((pn & ((48'd1 << (sh - 7'd1)) - 48'd1)) != 48'd0);
        if (rnd && (sticky || keep[0]))
            keep = keep + 25'd1;
        ef = 11'(e2);
        if (e2 >= 10'sd1)
        begin
            if (keep[24])
            begin
                keep = keep >> 1;
                ef = ef + 11'sd1;
            end
            if (ef >= 11'sd255)
                prod = {s2_sign_reg, 31'h7F80_0000};
            else
                prod = {s2_sign_reg, ef[7:0], keep[22:0]};
        end
        else
            prod = {s2_sign_reg, 7'd0, keep[23:0]};
        if (s2_sp_reg)
            prod = s2_spv_reg;
    end

    logic [31:0] s3_r_reg;
    fmt_t        s3_fmt_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_r_reg   <= prod;
            s3_fmt_reg <= s2_fmt_reg;
        end
    end

    // ---------------- Stage 4: clamp and find the FP8 exponent ----------------
    logic [30:0] mag;
    logic [31:0] maxb;

    always_comb
    begin
        maxb = (s3_fmt_reg == FMT_E4M3) ? E4M3_MAX_BITS : E5M2_MAX_BITS;
        mag = s3_r_reg[30:0];
        if (mag <= 31'h7F80_0000 && mag > maxb[30:0])
            mag = maxb[30:0];
    end

    logic        s4_zero_reg, s4_sign_reg;
    logic [30:0] s4_mag_reg;
    logic signed [9:0] s4_ne_reg;
    fmt_t        s4_fmt_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_zero_reg <= (s3_r_reg[30:0] == 31'd0);
            s4_sign_reg <= s3_r_reg[31];
            s4_mag_reg  <= mag;
            s4_ne_reg   <= 10'(mag[30:23]) - 10'sd127
                         + ((s3_fmt_reg == FMT_E4M3) ? 10'sd7 : 10'sd15);
            s4_fmt_reg  <= s3_fmt_reg;
        end
    end

    // ---------------- Stage 5: FP8 rounding and packing ----------------
    logic [22:0] mant;
    logic [23:0] dm;
    logic [3:0]  mbv, mlim;
    logic        r8, st8;
    logic signed [9:0] ne, emax;
    logic [7:0]  code;

    always_comb
    begin
        mant = s4_mag_reg[22:0];
        ne = s4_ne_reg;
        dm = '0;
        mbv = '0;
        r8 = 1'b0;
        st8 = 1'b0;
        if (s4_fmt_reg == FMT_E4M3)
        begin
            emax = 10'sd15;
            mlim = 4'd7;
        end
        else
        begin
            emax = 10'sd31;
            mlim = 4'd3;
        end
        code = '0;
        if (s4_zero_reg)
            code = '0;
        else if (ne <= 10'sd0)
        begin
            if (s4_fmt_reg == FMT_E4M3 ? (ne < -10'sd3) : (ne < -10'sd2))
                code = {s4_sign_reg, 7'd0};
            else
            begin
                dm = {1'b1, mant} >> (10'sd1 - ne);
                if (s4_fmt_reg == FMT_E4M3)
                    code = {s4_sign_reg, 4'd0, dm[22:20]};
                else
                    code = {s4_sign_reg, 5'd0, dm[22:21]};
            end
        end
        else
        begin
            if (ne > emax) ne = emax;
            if (s4_fmt_reg == FMT_E4M3)
            begin
                mbv = {1'b0, mant[22:20]};
                r8 = mant[19];
                st8 = mant[18:0] != 19'd0;
            end
            else
            begin
                mbv = {2'b00, mant[22:21]};
                r8 = mant[20];
                st8 = mant[19:0] != 20'd0;
            end
            if (r8 && (st8 || mbv[0]))
            begin
                mbv = mbv + 4'd1;
                if (mbv > mlim)
                begin
                    mbv = '0;
                    ne = ne + 10'sd1;
                    if (ne > emax)
                    begin
                        ne = emax;
                        mbv = (s4_fmt_reg == FMT_E4M3) ? 4'd6 : 4'd2;
                    end
                end
            end
            if (s4_fmt_reg == FMT_E4M3)
                code = {s4_sign_reg, ne[3:0], mbv[2:0]};
            else
                code = {s4_sign_reg, ne[4:0], mbv[1:0]};
        end
    end

    logic [7:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
            out_reg <= code;
    end

    assign m_axis_tvalid = vld_reg[4];
    assign m_axis_tdata  = out_reg;

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed during stall");
    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg == 5'b11111) && !m_axis_tready |-> !s_axis_tready)
        else $error("accepted a request into a full pipeline");
    a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> s_axis_tready)
        else $error("stalled with an empty first stage");
    a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] && s4_zero_reg && adv[4] |=> m_axis_tdata == 8'd0)
        else $error("zero product did not give zero code");
`endif

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled FP8 quantizer testbench
// Streams binary32 values through the quantizer under changing scale and
// format settings. Each code is checked against a bit-exact software
// multiply and FP8 conversion that is kept alongside the stream, and both
// sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import f8q_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    logic [31:0] scale_shadow = SCALE_RESET;
    fmt_t        format_shadow = FMT_E4M3;
    logic [7:0]  expected_codes[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          stall_count = 0;

    fp32_to_fp8_scaled_quantizer i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] value_bits
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [7:0] fp8_code
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void split_f32(input logic [31:0] x, output int ex,
                                      output logic [63:0] mant);
        logic [31:0] mf;
        mf = {9'd0, x[22:0]};
        if (x[30:23] != 8'd0)
        begin
            ex = int'(x[30:23]);
            mant = {40'd0, mf | 32'h0080_0000};
        end
        else
        begin
            ex = 1;
            while (mf[23] == 1'b0)
            begin
                mf = mf << 1;
                ex = ex - 1;
            end
            mant = {32'd0, mf};
        end
    endfunction

    function automatic logic [31:0] scaled_product(input logic [31:0] a,
                                                   input logic [31:0] b);
        logic [31:0] sgn;
        logic [31:0] aa;
        logic [31:0] ab;
        int          ea;
        int          eb;
        int          ex;
        int          sh;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] p;
        logic [63:0] keep;
        logic        rnd;
        logic        sticky;
        sgn = (a ^ b) & 32'h8000_0000;
        aa = a & 32'h7FFF_FFFF;
        ab = b & 32'h7FFF_FFFF;
        if (aa > 32'h7F80_0000) return a | 32'h0040_0000;
        if (ab > 32'h7F80_0000) return b | 32'h0040_0000;
        if ((aa == 32'h7F80_0000 && ab == 0) || (ab == 32'h7F80_0000 && aa == 0))
            return QNAN_DEFAULT;
        if (aa == 32'h7F80_0000 || ab == 32'h7F80_0000) return sgn | 32'h7F80_0000;
        if (aa == 0 || ab == 0) return sgn;
        split_f32(aa, ea, ma);
        split_f32(ab, eb, mb);
        p = ma * mb;
        ex = ea + eb - 127;
        if (p[47]) ex = ex + 1;
        else p = p << 1;
        if (ex >= 1) sh = 24;
        else if (ex > -40) sh = 25 - ex;
        else sh = 64;
        if (sh >= 64)
        begin
            keep = '0;
            rnd = 1'b0;
            sticky = 1'b1;
        end
        else
        begin
            keep = p >> sh;
            rnd = p[sh - 1];
            sticky = (p & ((64'd1 << (sh - 1)) - 64'd1)) != 0;
        end
        if (rnd && (sticky || keep[0])) keep = keep + 1;
        if (ex >= 1)
        begin
            if (keep == (64'd1 << 24))
            begin
                keep = keep >> 1;
                ex = ex + 1;
            end
            if (ex >= 255) return sgn | 32'h7F80_0000;
            return sgn | (32'(ex) << 23) | (keep[31:0] & 32'h007F_FFFF);
        end
        return sgn | keep[31:0];
    endfunction

    function automatic logic [7:0] fp8_from_product(input logic [31:0] r, input fmt_t fmt);
        int          mbits;
        int          bias;
        int          emax;
        int          ne;
        logic [31:0] maxbits;
        logic [31:0] satmant;
        logic [31:0] mag;
        logic [31:0] mant;
        logic [31:0] mb;
        logic [31:0] dm;
        logic [31:0] stk;
        logic        rnd;
        logic [31:0] sgn;
        mbits   = (fmt == FMT_E4M3) ? 3 : 2;
        bias    = (fmt == FMT_E4M3) ? 7 : 15;
        emax    = (fmt == FMT_E4M3) ? 15 : 31;
        maxbits = (fmt == FMT_E4M3) ? E4M3_MAX_BITS : E5M2_MAX_BITS;
        satmant = (fmt == FMT_E4M3) ? 32'd6 : 32'd2;
        sgn = {31'd0, r[31]};
        mag = r & 32'h7FFF_FFFF;
        if (mag == 0) return 8'h00;
        // NaN magnitudes escape the clamp and saturate the exponent below.
        if (mag <= 32'h7F80_0000 && mag > maxbits) mag = maxbits;
        mant = mag & 32'h007F_FFFF;
        ne = int'(mag >> 23) - 127 + bias;
        if (ne <= 0)
        begin
            if (ne < -mbits) return 8'(sgn << 7);
            dm = (mant | 32'h0080_0000) >> (1 - ne);
            return 8'((sgn << 7) | ((dm >> (23 - mbits)) & ((32'd1 << mbits) - 1)));
        end
        if (ne > emax) ne = emax;
        mb  = (mant >> (23 - mbits)) & ((32'd1 << mbits) - 1);
        rnd = mant[22 - mbits];
        stk = mant & ((32'd1 << (22 - mbits)) - 1);
        if (rnd && (stk != 0 || mb[0]))
        begin
            mb = mb + 1;
            if (mb > (32'd1 << mbits) - 1)
            begin
                mb = 0;
                ne = ne + 1;
                if (ne > emax)
                begin
                    ne = emax;
                    mb = satmant;
                end
            end
        end
        return 8'((sgn << 7) | (32'(ne) << mbits) | mb);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_codes.size() == 0)
                report_mismatch($sformatf("unexpected code %02h", m_axis_tdata));
            else
            begin
                logic [7:0] want;
                want = expected_codes.pop_front();
                if (m_axis_tdata !== want)
                    report_mismatch($sformatf("fp8_code %02h, want %02h", m_axis_tdata, want));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Called at a falling edge; returns at a falling edge with tvalid still
    // high so that back-to-back requests toggle it only for a random idle gap.
    task automatic send_value(input logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge clk); while (!s_axis_tready);
        expected_codes.push_back(fp8_from_product(scaled_product(v, scale_shadow),
                                                  format_shadow));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_codes.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 1'b0} << 1;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == ADDR_SCALE) scale_shadow = data;
        else format_shadow = fmt_t'(data[0]);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(5))
            0, 1:    v[30:23] = 8'($urandom_range(100, 145));
            2:       v[30:23] = 8'($urandom_range(118, 135));
            3:       v[19:0]  = ($urandom_range(1)) ? 20'h80000 : 20'h00000;
            4:
            begin
                case ($urandom_range(3))
                    0: v[30:0] = 31'h0;
                    1: v[30:0] = 31'h7F80_0000;
                    2: v[30:23] = 8'hFF;
                    default: v[30:23] = 8'h00;
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    logic [31:0] edge_values[12] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
        32'h7FC0_0001, 32'hFFA0_0000, 32'h43E0_0000, 32'hC3E8_0000,
        32'h4770_0000, 32'h3B10_0000, 32'h0000_0001, 32'h7F7F_FFFF
    };

    task automatic test_edge_values();
        apb_write(ADDR_FORMAT, {31'd0, FMT_E4M3});
        foreach (edge_values[i]) send_value(edge_values[i]);
        apb_write(ADDR_FORMAT, {31'd0, FMT_E5M2});
        foreach (edge_values[i]) send_value(edge_values[i]);
    endtask

    task automatic test_special_scales();
        apb_write(ADDR_SCALE, 32'h0000_0000);
        send_value(32'hFF80_0000);
        apb_write(ADDR_SCALE, 32'hFFFF_FFFF);
        send_value(32'h3F80_0000);
        apb_write(ADDR_SCALE, 32'h0000_0001);
        send_value(32'h7F7F_FFFF);
        apb_write(ADDR_SCALE, 32'h7F80_0000);
        send_value(32'h8000_0000);
    endtask

    task automatic test_random_phase(input int s_pct, input int r_pct);
        logic [31:0] sc;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int chunk = 0; chunk < 3; chunk++)
        begin
            case ($urandom_range(2))
                0: sc = 32'h3F80_0000;
                1: sc = {1'($urandom_range(1)), 8'($urandom_range(107, 147)), 23'($urandom())};
                default: sc = $urandom();
            endcase
            apb_write(ADDR_SCALE, sc);
            apb_write(ADDR_FORMAT, {31'd0, 1'($urandom_range(1))});
            for (int n = 0; n < 50; n++)
            begin
                // Once per phase, hold off until the pipeline has emptied.
                if (n == 25 && chunk == 1) wait_idle();
                send_value(random_value());
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_edge_values();
        test_special_scales();
        test_random_phase(26, 87);
        test_random_phase(87, 26);
        test_random_phase(0, 0);
        wait_idle();
        while (expected_codes.size() != 0)
            report_mismatch($sformatf("missing code %02h", expected_codes.pop_front()));
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
